/* rtl/udr_pkg.sv */
package udr_pkg;

  localparam int TICKS_PER_SECOND_DEF = 100;
  localparam int NAME_CHARS_DEF       = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_IP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_TYPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_VER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_NAME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAND_SEED   = 3'd5;

  localparam logic [31:0] LFSR_TAPS     = 32'h8020_0003;
  localparam logic [31:0] LFSR_RESET    = 32'd1;
  localparam logic [7:0]  PROTO_RESET   = 8'd1;
  localparam logic [4:0]  FLAGS_ALL     = 5'h1f;
  localparam logic [7:0]  MAC_BCAST_OCT = 8'hff;

  // request byte positions
  localparam logic [4:0] REQ_VER_POS  = 5'd8;
  localparam logic [4:0] REQ_TYPE_POS = 5'd9;
  localparam logic [4:0] REQ_MAC_POS  = 5'd10;
  localparam logic [4:0] REQ_END_POS  = 5'd16;
  localparam logic [4:0] REQ_MIN_LAST = 5'd15;
  localparam logic [4:0] BYTE_POS_MAX = 5'd31;

  // answer byte positions
  localparam logic [4:0] ANS_MAC_POS    = 5'd12;
  localparam logic [4:0] ANS_UPTIME_POS = 5'd18;
  localparam logic [4:0] ANS_TYPE_POS   = 5'd22;
  localparam logic [4:0] ANS_NAME_POS   = 5'd23;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SEND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic idle;
    logic byte_fire;
    logic req_end;
    logic tick_fire;
    logic arm;
    logic emit_start;
    logic emitting;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic deadline_passed;
    logic mod_busy;
    logic emit_done;
  } dp_status_t;

  function automatic logic [7:0] req_magic(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6e;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h66;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h6e;
      3'd6:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ans_magic(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6e;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h64;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h73;
      4'd6:    c = 8'h63;
      4'd7:    c = 8'h6f;
      4'd8:    c = 8'h76;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/udr_lfsr_mod.sv */
module udr_lfsr_mod #(
  parameter int TICKS_PER_SECOND = udr_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] value,
  output logic        busy,
  output logic [31:0] rem
);

  localparam int          Span  = 2 * TICKS_PER_SECOND;
  localparam int          RemW  = $clog2(Span);
  localparam int          Shift = 32 + RemW;
  // floor(2^Shift / Span); the quotient estimate is low by at most one
  localparam logic [32:0] Recip = 33'((65'd1 << Shift) / 65'(Span));
  localparam logic [31:0] SpanC = 32'(Span);

  logic            busy_r, busy_nxt;
  logic [1:0]      step_r, step_nxt;
  logic [31:0]     quo_r, quo_nxt;
  logic [31:0]     diff_r, diff_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic [64:0]     prod;
  logic [31:0]     back;
  logic [31:0]     diff_sub;

  // value holds still while busy
  assign prod     = 65'(value) * 65'(Recip);
  assign back     = quo_r * SpanC;
  assign diff_sub = diff_r - SpanC;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    diff_nxt = diff_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd0: quo_nxt = 32'(prod >> Shift);
        2'd1: diff_nxt = value - back;
        default: begin
          // one correction step brings the remainder below the span
          rem_nxt  = (diff_r >= SpanC) ? diff_sub[RemW-1:0] : diff_r[RemW-1:0];
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      step_r <= '0;
      quo_r  <= '0;
      diff_r <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      quo_r  <= quo_nxt;
      diff_r <= diff_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign rem  = 32'(rem_r);

endmodule

/* rtl/udr_ctrl.sv */
module udr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  input  logic                in_tlast,
  output logic                in_tready,
  input  udr_pkg::dp_status_t status,
  output udr_pkg::ctl_cmd_t   cmd
);

  udr_pkg::state_t state_r, state_nxt;
  logic            fire;

  assign fire = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      udr_pkg::ST_IDLE: begin
        if (cmd.arm) begin
          state_nxt = udr_pkg::ST_WAIT;
        end
      end
      udr_pkg::ST_WAIT: begin
        if (cmd.tick_fire && status.deadline_passed) begin
          state_nxt = udr_pkg::ST_SEND;
        end
      end
      udr_pkg::ST_SEND: begin
        if (cmd.tick_fire) begin
          state_nxt = udr_pkg::ST_EMIT;
        end
      end
      udr_pkg::ST_EMIT: begin
        if (status.emit_done) begin
          state_nxt = udr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = udr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = !status.mod_busy && (state_r != udr_pkg::ST_EMIT);
    cmd.idle       = (state_r == udr_pkg::ST_IDLE);
    cmd.byte_fire  = fire && in_tuser;
    cmd.req_end    = fire && in_tuser && in_tlast;
    cmd.tick_fire  = fire && !in_tuser;
    cmd.arm        = cmd.req_end && cmd.idle && status.req_ok;
    cmd.emit_start = cmd.tick_fire && (state_r == udr_pkg::ST_SEND);
    cmd.emitting   = (state_r == udr_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/udr_datapath.sv */
module udr_datapath #(
  parameter int TICKS_PER_SECOND = udr_pkg::TICKS_PER_SECOND_DEF,
  parameter int NAME_CHARS       = udr_pkg::NAME_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  udr_pkg::ctl_cmd_t                 cmd,
  output udr_pkg::dp_status_t               status,
  input  logic [7:0]                        data_byte,
  input  logic                              cfg_we,
  input  logic [udr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [udr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast
);

  localparam logic [3:0] NameMax = 4'(NAME_CHARS);

  function automatic logic [7:0] mac_octet(input logic [47:0] mac, input logic [2:0] i);
    logic [7:0] o;
    case (i)
      3'd0:    o = mac[47:40];
      3'd1:    o = mac[39:32];
      3'd2:    o = mac[31:24];
      3'd3:    o = mac[23:16];
      3'd4:    o = mac[15:8];
      3'd5:    o = mac[7:0];
      default: o = 8'h00;
    endcase
    return o;
  endfunction

  logic [47:0] own_mac_r;
  logic        host_ip_ok_r;
  logic [7:0]  device_type_r;
  logic [7:0]  proto_ver_r;
  logic [63:0] host_name_r;
  logic [31:0] lfsr_r, lfsr_nxt;
  logic [31:0] tick_count_r;
  logic [31:0] deadline_r;
  logic [4:0]  byte_pos_r;
  logic [4:0]  flags_r, flags_chk;
  logic        ignore_r;
  logic [31:0] uptime_r;
  logic [4:0]  emit_pos_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        seed_we;
  logic        mod_start;
  logic        mod_busy;
  logic [31:0] mod_rem;
  logic [4:0]  mac_idx;
  logic [7:0]  own_oct;
  logic        load;
  logic [7:0]  ans_byte;
  logic        ans_last;
  logic [4:0]  name_off;
  logic [3:0]  name_k;
  logic [7:0]  name_byte;
  logic [4:0]  ofs;

  assign seed_we   = cfg_we && (cfg_index == udr_pkg::REG_RAND_SEED);
  assign mod_start = cmd.arm || seed_we;

  udr_lfsr_mod #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (lfsr_r),
    .busy  (mod_busy),
    .rem   (mod_rem)
  );

  // request field checks for the byte at byte_pos_r
  assign mac_idx = byte_pos_r - udr_pkg::REQ_MAC_POS;
  assign own_oct = mac_octet(own_mac_r, mac_idx[2:0]);

  always_comb begin
    flags_chk = flags_r;
    if (byte_pos_r < udr_pkg::REQ_VER_POS) begin
      if (data_byte != udr_pkg::req_magic(byte_pos_r[2:0])) flags_chk[0] = 1'b0;
    end else if (byte_pos_r == udr_pkg::REQ_VER_POS) begin
      if (data_byte > proto_ver_r) flags_chk[1] = 1'b0;
    end else if (byte_pos_r == udr_pkg::REQ_TYPE_POS) begin
      if (data_byte != 8'h00 && data_byte != device_type_r) flags_chk[2] = 1'b0;
    end else if (byte_pos_r < udr_pkg::REQ_END_POS) begin
      if (data_byte != udr_pkg::MAC_BCAST_OCT) flags_chk[3] = 1'b0;
      if (data_byte != own_oct) flags_chk[4] = 1'b0;
    end
  end

  assign status.req_ok = !ignore_r && host_ip_ok_r &&
                         (byte_pos_r >= udr_pkg::REQ_MIN_LAST) &&
                         (flags_chk[2:0] == 3'b111) && (flags_chk[4:3] != 2'b00);
  assign status.deadline_passed = tick_count_r > deadline_r;
  assign status.mod_busy        = mod_busy;

  assign lfsr_nxt = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? udr_pkg::LFSR_TAPS : 32'd0);

  // answer byte selection
  assign name_off  = emit_pos_r - udr_pkg::ANS_NAME_POS;
  assign name_k    = name_off[3:0];
  assign name_byte = host_name_r[{name_k[2:0], 3'b000} +: 8];
  assign ofs       = emit_pos_r - udr_pkg::ANS_MAC_POS;

  always_comb begin
    ans_last = 1'b0;
    ans_byte = 8'h00;
    if (emit_pos_r < udr_pkg::ANS_MAC_POS) begin
      ans_byte = udr_pkg::ans_magic(emit_pos_r[3:0]);
    end else if (emit_pos_r < udr_pkg::ANS_UPTIME_POS) begin
      ans_byte = mac_octet(own_mac_r, ofs[2:0]);
    end else if (emit_pos_r < udr_pkg::ANS_TYPE_POS) begin
      case (emit_pos_r[1:0])
        2'd2:    ans_byte = uptime_r[7:0];
        2'd3:    ans_byte = uptime_r[15:8];
        2'd0:    ans_byte = uptime_r[23:16];
        default: ans_byte = uptime_r[31:24];
      endcase
    end else if (emit_pos_r == udr_pkg::ANS_TYPE_POS) begin
      ans_byte = device_type_r;
    end else begin
      // name runs until a zero byte or the character limit, then the closing nul
      if (name_k >= NameMax || name_byte == 8'h00) begin
        ans_last = 1'b1;
      end else begin
        ans_byte = name_byte;
      end
    end
  end

  assign load             = cmd.emitting && (!out_valid_r || out_tready);
  assign status.emit_done = load && ans_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r     <= '0;
      host_ip_ok_r  <= 1'b0;
      device_type_r <= '0;
      proto_ver_r   <= udr_pkg::PROTO_RESET;
      host_name_r   <= '0;
      lfsr_r        <= udr_pkg::LFSR_RESET;
      tick_count_r  <= '0;
      deadline_r    <= '0;
      byte_pos_r    <= '0;
      flags_r       <= udr_pkg::FLAGS_ALL;
      ignore_r      <= 1'b0;
      emit_pos_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          udr_pkg::REG_OWN_MAC:     own_mac_r     <= cfg_data[47:0];
          udr_pkg::REG_HOST_IP:     host_ip_ok_r  <= (cfg_data[31:0] != 32'd0);
          udr_pkg::REG_DEVICE_TYPE: device_type_r <= cfg_data[7:0];
          udr_pkg::REG_PROTO_VER:   proto_ver_r   <= cfg_data[7:0];
          udr_pkg::REG_HOST_NAME:   host_name_r   <= cfg_data;
          udr_pkg::REG_RAND_SEED:   lfsr_r        <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.arm) begin
        deadline_r <= tick_count_r + mod_rem;
        lfsr_r     <= lfsr_nxt;
      end
      if (cmd.byte_fire) begin
        if (cmd.req_end) begin
          byte_pos_r <= '0;
          flags_r    <= udr_pkg::FLAGS_ALL;
          ignore_r   <= 1'b0;
        end else begin
          flags_r  <= flags_chk;
          ignore_r <= ignore_r || !cmd.idle;
          if (byte_pos_r < udr_pkg::BYTE_POS_MAX) begin
            byte_pos_r <= byte_pos_r + 5'd1;
          end
        end
      end
      if (cmd.tick_fire) begin
        tick_count_r <= tick_count_r + 32'd1;
      end
      if (cmd.emit_start) begin
        emit_pos_r <= '0;
      end else if (load) begin
        emit_pos_r <= emit_pos_r + 5'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      uptime_r <= tick_count_r;
    end
    if (load) begin
      out_byte_r <= ans_byte;
      out_last_r <= ans_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/udp_discovery_responder_unit.sv */
// Discovery responder: the input stream carries request payload bytes
// (tuser high, tlast on the final byte) and clock ticks (tuser low). A request
// that passes its checks arms a reply deadline of the tick count plus a
// pseudo-random delay below two seconds; the delay remainder comes from a
// reciprocal multiply, a subtraction and one correction step taken in turn,
// so while that runs, after each accepted request, after a seed write and
// after reset, the input is held off. Once the deadline has passed, the
// second tick that follows starts the answer burst of 24 to 24 + NAME_CHARS
// bytes, one byte per cycle while out_tready is high, through the output
// register; the input is held off until the last answer byte is loaded
// there. The configuration port is always ready and is to be written by
// the user only while idle; the block itself does not enforce this.
module udp_discovery_responder_unit #(
  parameter int TICKS_PER_SECOND = udr_pkg::TICKS_PER_SECOND_DEF,
  parameter int NAME_CHARS       = udr_pkg::NAME_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tuser,   // req_type
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // out_byte
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [udr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udr_pkg::CFG_DATA_W-1:0] cfg_data
);

  udr_pkg::ctl_cmd_t   cmd;
  udr_pkg::dp_status_t status;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  udr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  udr_datapath #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .NAME_CHARS      (NAME_CHARS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .data_byte  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
